[sv/tlpt_pkg.sv]
package tlpt_pkg;

   localparam int L1_ENTRIES      = 4096;
   localparam int L2_ENTRIES      = 256;
   localparam int POOL_TABLES_DEF = 64;
   localparam int CTR_W           = 12;
   localparam int CNT_W           = 9;
   localparam int REQ_W           = 104;
   localparam int RSP_W           = 56;

   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_UNMAP = 2'd1;
   localparam logic [1:0] OP_XLATE = 2'd2;

   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_IN_USE   = 3'd1;
   localparam logic [2:0] STS_NO_TABLE = 3'd2;
   localparam logic [2:0] STS_FAULT    = 3'd3;
   localparam logic [2:0] STS_BAD_SIZE = 3'd4;

   localparam logic [31:0] SIZE_SECTION = 32'h0010_0000;
   localparam logic [31:0] SIZE_LARGE   = 32'h0001_0000;
   localparam logic [31:0] SIZE_SMALL   = 32'h0000_1000;

   localparam logic [1:0] L1_TAG_POINTER = 2'd1;
   localparam logic [1:0] L1_TAG_SECTION = 2'd2;
   localparam logic [1:0] L2_TAG_FAULT   = 2'd0;
   localparam logic [1:0] L2_TAG_LARGE   = 2'd1;
   localparam logic [1:0] L2_TAG_SMALL   = 2'd2;

   localparam logic [1:0] KIND_FAULT   = 2'd0;
   localparam logic [1:0] KIND_TABLE   = 2'd1;
   localparam logic [1:0] KIND_SECTION = 2'd2;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_RD1, S_DEC1, S_SCAN, S_CLR, S_RD2, S_DEC2,
      S_LCK_RD, S_LCK_CHK, S_LWR, S_RESP
   } state_type;

   typedef enum logic {L1A_REQ, L1A_CTR} l1a_type;
   typedef enum logic [1:0] {L1W_ZERO, L1W_SECTION, L1W_POINTER} l1w_type;
   typedef enum logic [1:0] {L2A_REQ, L2A_GROUP, L2A_CLEAR} l2a_type;
   typedef enum logic [1:0] {L2W_ZERO, L2W_SMALL, L2W_LARGE} l2w_type;
   typedef enum logic [2:0] {CW_FULL, CW_DEC1, CW_DEC16, CW_INC1, CW_INC16} cntw_type;
   typedef enum logic [3:0] {
      R_OK, R_IN_USE, R_NO_TABLE, R_FAULT, R_BAD_SIZE, R_XLATE_SEC, R_XLATE_PAGE,
      R_UNMAP_SEC, R_UNMAP_CLIP, R_UNMAP_SMALL, R_UNMAP_LARGE
   } res_type;

   typedef struct packed {
      logic     load_req;
      l1a_type  l1_asel;
      logic     l1_we;
      l1w_type  l1_wsel;
      l2a_type  l2_asel;
      logic     l2_we;
      l2w_type  l2_wsel;
      logic     cnt_we;
      cntw_type cnt_wsel;
      logic     cap_l1;
      logic     alloc;
      logic     pool_set;
      logic     pool_clr;
      logic     ctr_clr;
      logic     ctr_inc;
      logic     res_we;
      res_type  res_sel;
      logic     rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       size_small;
      logic       size_large;
      logic       size_section;
      logic [1:0] l1_kind;
      logic       cnt_full;
      logic [1:0] l2_tag;
      logic       ctr_init_last;
      logic       ctr_pool_last;
      logic       ctr_clear_last;
      logic       ctr_group_last;
      logic       pool_free;
      logic       out_free;
   } sts_type;

   function automatic logic [1:0] l1_kind(input logic [31:0] e);
      if (e[1:0] == L1_TAG_SECTION) begin
         return KIND_SECTION;
      end else if (e[1:0] == L1_TAG_POINTER) begin
         return KIND_TABLE;
      end
      return KIND_FAULT;
   endfunction

endpackage

[sv/two_level_io_page_table_core.sv]
// channel | dir | tdata fields, lowest bit first
// req_    | in  | op[1:0] virt_addr[33:2] target_addr[65:34] length[97:66], zero fill
// rsp_    | out | status[2:0] phys_result[34:3] unmapped_bytes[55:35]
// one request at a time: the first-level read settles it, or a second-level read follows
// (two registered table reads in series)
// allocating a table adds a pool scan over up to POOL_TABLES tables and a clear of all 256 entries;
// a large page adds a check of up to 16 entries (map only) and a write of 16 entries, one table port
// after reset all 4096 first-level entries are cleared, req_tready low
// a waiting response holds the controller before it returns to accept the next request
module two_level_io_page_table_core #(
   parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tlpt_pkg::REQ_W-1:0] req_tdata,  // op, virt_addr, target_addr, length
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tlpt_pkg::RSP_W-1:0] rsp_tdata   // status, phys_result, unmapped_bytes
);
   import tlpt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tlpt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .sts(sts), .cmd(cmd)
   );

   tlpt_datapath #(.POOL_TABLES(POOL_TABLES)) u_dp (
      .clock(clock), .reset(reset), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .cmd(cmd), .sts(sts)
   );
endmodule

[sv/tlpt_ram.sv]
module tlpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

[sv/tlpt_ctrl.sv]
module tlpt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tlpt_pkg::sts_type sts,
   output tlpt_pkg::cmd_type cmd
);
   import tlpt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.l1_asel = L1A_CTR;
            cmd.l1_we   = 1'b1;
            cmd.l1_wsel = L1W_ZERO;
            cmd.ctr_inc = 1'b1;
            if (sts.ctr_init_last) begin
               cmd.ctr_clr = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_RD1;
            end
         end
         S_RD1: state_in = S_DEC1;
         S_DEC1: begin
            cmd.cap_l1 = 1'b1;
            state_in   = S_RESP;
            cmd.res_we = 1'b1;
            case (sts.op)
               OP_MAP: begin
                  if (!(sts.size_small || sts.size_large || sts.size_section)) begin
                     cmd.res_sel = R_BAD_SIZE;
                  end else if (sts.size_section) begin
                     if (sts.l1_kind == KIND_SECTION ||
                         (sts.l1_kind == KIND_TABLE && !sts.cnt_full)) begin
                        cmd.res_sel = R_IN_USE;
                     end else begin
                        cmd.pool_clr = (sts.l1_kind == KIND_TABLE);
                        cmd.l1_we    = 1'b1;
                        cmd.l1_wsel  = L1W_SECTION;
                        cmd.res_sel  = R_OK;
                     end
                  end else if (sts.l1_kind == KIND_SECTION) begin
                     cmd.res_sel = R_IN_USE;
                  end else if (sts.l1_kind == KIND_FAULT) begin
                     cmd.res_we  = 1'b0;
                     cmd.ctr_clr = 1'b1;
                     state_in    = S_SCAN;
                  end else if (sts.size_small) begin
                     cmd.res_we = 1'b0;
                     state_in   = S_RD2;
                  end else begin
                     cmd.res_we  = 1'b0;
                     cmd.ctr_clr = 1'b1;
                     state_in    = S_LCK_RD;
                  end
               end
               OP_UNMAP: begin
                  if (sts.l1_kind == KIND_SECTION) begin
                     cmd.l1_we   = 1'b1;
                     cmd.l1_wsel = L1W_ZERO;
                     cmd.res_sel = R_UNMAP_SEC;
                  end else if (sts.l1_kind == KIND_FAULT) begin
                     cmd.res_sel = R_UNMAP_CLIP;
                  end else begin
                     cmd.res_we = 1'b0;
                     state_in   = S_RD2;
                  end
               end
               OP_XLATE: begin
                  if (sts.l1_kind == KIND_SECTION) begin
                     cmd.res_sel = R_XLATE_SEC;
                  end else if (sts.l1_kind == KIND_FAULT) begin
                     cmd.res_sel = R_FAULT;
                  end else begin
                     cmd.res_we = 1'b0;
                     state_in   = S_RD2;
                  end
               end
               default: cmd.res_sel = R_BAD_SIZE;
            endcase
         end
         S_SCAN: begin
            if (sts.pool_free) begin
               cmd.pool_set = 1'b1;
               cmd.alloc    = 1'b1;
               cmd.l1_we    = 1'b1;
               cmd.l1_wsel  = L1W_POINTER;
               cmd.cnt_we   = 1'b1;
               cmd.cnt_wsel = CW_FULL;
               cmd.ctr_clr  = 1'b1;
               state_in     = S_CLR;
            end else if (sts.ctr_pool_last) begin
               cmd.res_we  = 1'b1;
               cmd.res_sel = R_NO_TABLE;
               state_in    = S_RESP;
            end else begin
               cmd.ctr_inc = 1'b1;
            end
         end
         S_CLR: begin
            cmd.l2_asel = L2A_CLEAR;
            cmd.l2_we   = 1'b1;
            cmd.l2_wsel = L2W_ZERO;
            cmd.ctr_inc = 1'b1;
            if (sts.ctr_clear_last) begin
               cmd.ctr_clr = 1'b1;
               state_in    = sts.size_small ? S_RD2 : S_LCK_RD;
            end
         end
         S_RD2: state_in = S_DEC2;
         S_DEC2: begin
            state_in   = S_RESP;
            cmd.res_we = 1'b1;
            case (sts.op)
               OP_MAP: begin
                  if (sts.l2_tag != L2_TAG_FAULT) begin
                     cmd.res_sel = R_IN_USE;
                  end else begin
                     cmd.l2_we    = 1'b1;
                     cmd.l2_wsel  = L2W_SMALL;
                     cmd.cnt_we   = 1'b1;
                     cmd.cnt_wsel = CW_DEC1;
                     cmd.res_sel  = R_OK;
                  end
               end
               OP_UNMAP: begin
                  if (sts.l2_tag == L2_TAG_FAULT) begin
                     cmd.res_sel = R_UNMAP_SMALL;
                  end else if (sts.l2_tag[1]) begin
                     cmd.l2_we    = 1'b1;
                     cmd.l2_wsel  = L2W_ZERO;
                     cmd.cnt_we   = 1'b1;
                     cmd.cnt_wsel = CW_INC1;
                     cmd.res_sel  = R_UNMAP_SMALL;
                  end else begin
                     cmd.res_we  = 1'b0;
                     cmd.ctr_clr = 1'b1;
                     state_in    = S_LWR;
                  end
               end
               default: begin
                  cmd.res_sel = (sts.l2_tag == L2_TAG_FAULT) ? R_FAULT : R_XLATE_PAGE;
               end
            endcase
         end
         S_LCK_RD: begin
            cmd.l2_asel = L2A_GROUP;
            state_in    = S_LCK_CHK;
         end
         S_LCK_CHK: begin
            if (sts.l2_tag != L2_TAG_FAULT) begin
               cmd.res_we  = 1'b1;
               cmd.res_sel = R_IN_USE;
               state_in    = S_RESP;
            end else if (sts.ctr_group_last) begin
               cmd.ctr_clr = 1'b1;
               state_in    = S_LWR;
            end else begin
               cmd.ctr_inc = 1'b1;
               state_in    = S_LCK_RD;
            end
         end
         S_LWR: begin
            cmd.l2_asel = L2A_GROUP;
            cmd.l2_we   = 1'b1;
            cmd.l2_wsel = (sts.op == OP_MAP) ? L2W_LARGE : L2W_ZERO;
            cmd.ctr_inc = 1'b1;
            if (sts.ctr_group_last) begin
               cmd.ctr_clr  = 1'b1;
               cmd.cnt_we   = 1'b1;
               cmd.cnt_wsel = (sts.op == OP_MAP) ? CW_DEC16 : CW_INC16;
               cmd.res_we   = 1'b1;
               cmd.res_sel  = (sts.op == OP_MAP) ? R_OK : R_UNMAP_LARGE;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

[sv/tlpt_datapath.sv]
module tlpt_datapath #(
   parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [tlpt_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tlpt_pkg::RSP_W-1:0] rsp_tdata,
   input  tlpt_pkg::cmd_type          cmd,
   output tlpt_pkg::sts_type          sts
);
   import tlpt_pkg::*;

   localparam int PW       = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int L1_AW    = $clog2(L1_ENTRIES);
   localparam int L2_DEPTH = POOL_TABLES * L2_ENTRIES;
   localparam int L2_AW    = $clog2(L2_DEPTH);

   logic [1:0]             op_ff, op_in;
   logic [31:0]            va_ff, va_in, pa_ff, pa_in, len_ff, len_in;
   logic [31:0]            l1e_ff, l1e_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CTR_W-1:0]       ctr_ff, ctr_in;
   logic [POOL_TABLES-1:0] pool_ff, pool_in;
   logic [2:0]             res_status_ff, res_status_in;
   logic [31:0]            res_phys_ff, res_phys_in;
   logic [20:0]            res_bytes_ff, res_bytes_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [L1_AW-1:0] l1_addr;
   logic [31:0]      l1_wdata, l1_q;
   logic [PW+7:0]    l2_full_addr;
   logic [31:0]      l2_wdata, l2_q;
   logic [CNT_W-1:0] cnt_wdata, cnt_q;
   logic [PW-1:0]    ctr_pool;
   logic [20:0]      clip_bytes;

   assign ctr_pool = ctr_ff[PW-1:0];

   always_comb begin
      l1_addr = (cmd.l1_asel == L1A_CTR) ? ctr_ff[L1_AW-1:0] : va_ff[31:20];
      unique case (cmd.l1_wsel)
         L1W_SECTION: l1_wdata = {pa_ff[31:20], 18'd0, L1_TAG_SECTION};
         L1W_POINTER: l1_wdata = ({{(32-PW){1'b0}}, ctr_pool} << 10) |
                                 {30'd0, L1_TAG_POINTER};
         default:     l1_wdata = '0;
      endcase
      unique case (cmd.l2_asel)
         L2A_GROUP: l2_full_addr = {l1e_ff[10 +: PW], va_ff[19:16], ctr_ff[3:0]};
         L2A_CLEAR: l2_full_addr = {l1e_ff[10 +: PW], ctr_ff[7:0]};
         default:   l2_full_addr = {l1e_ff[10 +: PW], va_ff[19:12]};
      endcase
      unique case (cmd.l2_wsel)
         L2W_SMALL: l2_wdata = {pa_ff[31:12], 10'd0, L2_TAG_SMALL};
         L2W_LARGE: l2_wdata = {pa_ff[31:16], 14'd0, L2_TAG_LARGE};
         default:   l2_wdata = '0;
      endcase
      unique case (cmd.cnt_wsel)
         CW_DEC1:  cnt_wdata = cnt_ff - CNT_W'(1);
         CW_DEC16: cnt_wdata = cnt_ff - CNT_W'(16);
         CW_INC1:  cnt_wdata = cnt_ff + CNT_W'(1);
         CW_INC16: cnt_wdata = cnt_ff + CNT_W'(16);
         default:  cnt_wdata = CNT_W'(L2_ENTRIES);
      endcase
   end

   tlpt_ram #(.WIDTH(32), .DEPTH(L1_ENTRIES)) u_l1 (
      .clock(clock), .we(cmd.l1_we), .addr(l1_addr), .wdata(l1_wdata), .rdata(l1_q)
   );

   tlpt_ram #(.WIDTH(32), .DEPTH(L2_DEPTH)) u_l2 (
      .clock(clock), .we(cmd.l2_we), .addr(l2_full_addr[L2_AW-1:0]),
      .wdata(l2_wdata), .rdata(l2_q)
   );

   tlpt_ram #(.WIDTH(CNT_W), .DEPTH(L1_ENTRIES)) u_cnt (
      .clock(clock), .we(cmd.cnt_we), .addr(va_ff[31:20]), .wdata(cnt_wdata), .rdata(cnt_q)
   );

   assign clip_bytes = (len_ff > SIZE_SECTION) ? SIZE_SECTION[20:0] : len_ff[20:0];

   always_comb begin
      op_in         = op_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      len_in        = len_ff;
      l1e_in        = l1e_ff;
      cnt_in        = cnt_ff;
      ctr_in        = ctr_ff;
      pool_in       = pool_ff;
      res_status_in = res_status_ff;
      res_phys_in   = res_phys_ff;
      res_bytes_in  = res_bytes_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (cmd.load_req) begin
         op_in  = req_tdata[1:0];
         va_in  = req_tdata[33:2];
         pa_in  = req_tdata[65:34];
         len_in = req_tdata[97:66];
      end
      if (cmd.cap_l1) begin
         l1e_in = l1_q;
         cnt_in = cnt_q;
      end
      if (cmd.alloc) begin
         l1e_in = l1_wdata;
         cnt_in = CNT_W'(L2_ENTRIES);
      end
      if (cmd.ctr_clr) begin
         ctr_in = '0;
      end else if (cmd.ctr_inc) begin
         ctr_in = ctr_ff + CTR_W'(1);
      end
      if (cmd.pool_set) begin
         pool_in[ctr_pool] = 1'b1;
      end
      if (cmd.pool_clr) begin
         pool_in[l1_q[10 +: PW]] = 1'b0;
      end
      if (cmd.res_we) begin
         res_phys_in  = '0;
         res_bytes_in = '0;
         unique case (cmd.res_sel)
            R_OK:        res_status_in = STS_OK;
            R_IN_USE:    res_status_in = STS_IN_USE;
            R_NO_TABLE:  res_status_in = STS_NO_TABLE;
            R_FAULT:     res_status_in = STS_FAULT;
            R_XLATE_SEC: begin
               res_status_in = STS_OK;
               res_phys_in   = {l1_q[31:20], va_ff[19:0]};
            end
            R_XLATE_PAGE: begin
               res_status_in = STS_OK;
               res_phys_in   = (l2_q[1:0] == L2_TAG_LARGE) ? {l2_q[31:16], va_ff[15:0]}
                                                          : {l2_q[31:12], va_ff[11:0]};
            end
            R_UNMAP_SEC: begin
               res_status_in = STS_OK;
               res_bytes_in  = SIZE_SECTION[20:0];
            end
            R_UNMAP_CLIP: begin
               res_status_in = STS_OK;
               res_bytes_in  = clip_bytes;
            end
            R_UNMAP_SMALL: begin
               res_status_in = STS_OK;
               res_bytes_in  = SIZE_SMALL[20:0];
            end
            R_UNMAP_LARGE: begin
               res_status_in = STS_OK;
               res_bytes_in  = SIZE_LARGE[20:0];
            end
            default:     res_status_in = STS_BAD_SIZE;
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_bytes_ff, res_phys_ff, res_status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff       <= '0;
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctr_ff       <= ctr_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      len_ff        <= len_in;
      l1e_ff        <= l1e_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_phys_ff   <= res_phys_in;
      res_bytes_ff  <= res_bytes_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      sts.op             = op_ff;
      sts.size_small     = (len_ff == SIZE_SMALL);
      sts.size_large     = (len_ff == SIZE_LARGE);
      sts.size_section   = (len_ff == SIZE_SECTION);
      sts.l1_kind        = l1_kind(l1_q);
      sts.cnt_full       = (cnt_q == CNT_W'(L2_ENTRIES));
      sts.l2_tag         = l2_q[1:0];
      sts.ctr_init_last  = (ctr_ff == CTR_W'(L1_ENTRIES - 1));
      sts.ctr_pool_last  = (ctr_ff == CTR_W'(POOL_TABLES - 1));
      sts.ctr_clear_last = (ctr_ff[7:0] == 8'hFF);
      sts.ctr_group_last = (ctr_ff[3:0] == 4'hF);
      sts.pool_free      = !pool_ff[ctr_pool];
      sts.out_free       = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

[sv/tlpt_checker.sv]
module tlpt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [tlpt_pkg::RSP_W-1:0] rsp_tdata
);
   import tlpt_pkg::*;

   // one request in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= STS_BAD_SIZE)
      else $error("status code out of range");

   a_phys_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != STS_OK |-> rsp_tdata[34:3] == 32'd0 &&
      rsp_tdata[55:35] == 21'd0)
      else $error("address or size on a failed response");

   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:35] <= 21'h10_0000)
      else $error("released size above one section");
endmodule

bind two_level_io_page_table_core tlpt_checker u_tlpt_checker (.*);
